>>> src/hbkd_pkg.sv
// Shared types, constants and scancode translation for the boot keyboard decoder.
package hbkd_pkg;

    localparam int SLOT_COUNT   = 6;
    localparam int CODE_W       = 8;
    localparam int CHAR_W       = 7;
    localparam int LEN_W        = 7;
    localparam int S_DATA_W     = 64;
    localparam int M_DATA_W     = 24;

    localparam logic [CODE_W-1:0] KEY_ENTER     = 8'h28;
    localparam logic [CODE_W-1:0] KEY_ESC       = 8'h29;
    localparam logic [CODE_W-1:0] KEY_BACKSPACE = 8'h2A;
    localparam logic [CODE_W-1:0] KEY_TAB       = 8'h2B;
    localparam logic [CODE_W-1:0] KEY_SPACE     = 8'h2C;
    localparam logic [CODE_W-1:0] SHIFT_LEFT    = 8'h02;
    localparam logic [CODE_W-1:0] SHIFT_RIGHT   = 8'h20;
    localparam logic [CODE_W-1:0] CODE_LIMIT    = 8'd128;
    localparam logic [CODE_W-1:0] LETTER_FIRST  = 8'h04;
    localparam logic [CODE_W-1:0] LETTER_LAST   = 8'h1D;
    localparam logic [CODE_W-1:0] TABLE_FIRST   = 8'h1E;
    localparam logic [CODE_W-1:0] TABLE_LAST    = 8'h38;
    localparam logic [CODE_W-1:0] LOWER_OFFSET  = 8'h5D;  // 'a' minus the first letter code
    localparam logic [CODE_W-1:0] UPPER_OFFSET  = 8'h3D;  // 'A' minus the first letter code

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE  = 7'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BS       = 7'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB      = 7'h09;
    localparam logic [CHAR_W-1:0] CHAR_ESC      = 7'h1B;
    localparam logic [CHAR_W-1:0] CHAR_BLANK    = 7'h20;

    localparam logic OP_REPORT     = 1'b0;
    localparam logic OP_DISCONNECT = 1'b1;

    localparam logic [LEN_W-1:0] MIN_REPORT_LEN = 7'd8;

    // What one lane found for its slot.
    typedef struct packed {
        logic               emit;
        logic               special;
        logic [CHAR_W-1:0]  ascii;
        logic [CODE_W-1:0]  code;
    } lane_res_t;

    typedef lane_res_t [SLOT_COUNT-1:0] lane_vec_t;
    typedef logic [SLOT_COUNT-1:0][CODE_W-1:0] slot_vec_t;

    // US layout for codes 0x1E..0x38; the control and space codes are decoded earlier.
    function automatic logic [CHAR_W-1:0] table_char(input logic [CODE_W-1:0] code,
                                                      input logic shift);
        logic [CHAR_W-1:0] ch;
        begin
            ch = '0;
            case (code)
                8'h1E: ch = shift ? 7'h21 : 7'h31;
                8'h1F: ch = shift ? 7'h40 : 7'h32;
                8'h20: ch = shift ? 7'h23 : 7'h33;
                8'h21: ch = shift ? 7'h24 : 7'h34;
                8'h22: ch = shift ? 7'h25 : 7'h35;
                8'h23: ch = shift ? 7'h5E : 7'h36;
                8'h24: ch = shift ? 7'h26 : 7'h37;
                8'h25: ch = shift ? 7'h2A : 7'h38;
                8'h26: ch = shift ? 7'h28 : 7'h39;
                8'h27: ch = shift ? 7'h29 : 7'h30;
                8'h2D: ch = shift ? 7'h5F : 7'h2D;
                8'h2E: ch = shift ? 7'h2B : 7'h3D;
                8'h2F: ch = shift ? 7'h7B : 7'h5B;
                8'h30: ch = shift ? 7'h7D : 7'h5D;
                8'h31: ch = shift ? 7'h7C : 7'h5C;
                8'h33: ch = shift ? 7'h3A : 7'h3B;
                8'h34: ch = shift ? 7'h22 : 7'h27;
                8'h35: ch = shift ? 7'h7E : 7'h60;
                8'h36: ch = shift ? 7'h3C : 7'h2C;
                8'h37: ch = shift ? 7'h3E : 7'h2E;
                8'h38: ch = shift ? 7'h3F : 7'h2F;
                default: ch = '0;
            endcase
            return ch;
        end
    endfunction

    // Full translation for a non-control code; zero means no character.
    function automatic logic [CHAR_W-1:0] translate(input logic [CODE_W-1:0] code,
                                                     input logic shift);
        logic [CODE_W-1:0] sum;
        logic [CHAR_W-1:0] ch;
        begin
            sum = code + (shift ? UPPER_OFFSET : LOWER_OFFSET);
            ch  = '0;
            if (code >= CODE_LIMIT) begin
                ch = '0;
            end else if (code >= LETTER_FIRST && code <= LETTER_LAST) begin
                ch = sum[CHAR_W-1:0];
            end else if (code >= TABLE_FIRST && code <= TABLE_LAST) begin
                ch = table_char(code, shift);
            end
            return ch;
        end
    endfunction

endpackage

>>> src/hid_boot_keyboard_decoder_core.sv
// Top level of the boot keyboard report decoder: input stage, six decode lanes and merge stage.
//
//  channel | direction | tdata fields (low bit up)                           | tuser / tlast
//  s_      | in        | report_length[6:0] modifier_byte[14:7]               | tuser: operation
//          |           | key_slot_0..5 at [22:15]..[62:55], bit 63 zero       |
//  m_      | out       | key_code[7:0] modifier_copy[15:8] ascii_char[22:16]  | tuser: special_key
//          |           | bit 23 zero                                          | tlast: last_event
//
// A report is decoded in the cycle it is accepted: six lanes each compare one slot with the six
// remembered keys and translate it, and the results are latched in the merge stage.
// A report that yields key words then occupies the merge stage until the last of them has left it,
// one word per cycle while m_tready does not stall the output; the next report is accepted in
// the same cycle the last pending key word moves into the output register.
// Short reports and disconnects produce no words.
// Reset (aresetn low, synchronous) clears the remembered keys, the pending mask and the
// output valid flag. A stall on m_tready holds the output register and, once the merge stage
// is still holding events, holds s_tready low.
module hid_boot_keyboard_decoder_core
    import hbkd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // report_length, modifier_byte, key_slot_0..5
    input  logic                 s_tuser,   // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // key_code, modifier_copy, ascii_char
    output logic                 m_tuser,   // special_key
    output logic                 m_tlast    // last_event
);

    // Keys of the last valid report; compared against every new slot.
    slot_vec_t         prev_reg, prev_next;
    slot_vec_t         slots;
    lane_vec_t         lanes;
    logic [LEN_W-1:0]  report_len;
    logic [CODE_W-1:0] modifier;
    logic              shift;
    logic              accept;
    logic              good_report;
    logic              disconnect;
    logic              merge_ready;

    assign report_len = s_tdata[LEN_W-1:0];
    assign modifier   = s_tdata[LEN_W +: CODE_W];

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slots[i] = s_tdata[LEN_W + CODE_W + CODE_W*i +: CODE_W];
        end
    end

    // Either shift key selects the shifted table.
    assign shift       = (modifier & (SHIFT_LEFT | SHIFT_RIGHT)) != '0;
    assign s_tready    = merge_ready;
    assign accept      = s_tvalid && s_tready;
    assign disconnect  = accept && (s_tuser == OP_DISCONNECT);
    assign good_report = accept && (s_tuser == OP_REPORT) && (report_len >= MIN_REPORT_LEN);

    // Every slot of a valid report is remembered, including rollover and unmapped codes.
    always_comb begin
        prev_next = prev_reg;
        if (disconnect) begin
            prev_next = '0;
        end else if (good_report) begin
            prev_next = slots;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else begin
            prev_reg <= prev_next;
        end
    end

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_lane
        hbkd_lane u_lane (
            .code_i  (slots[g]),
            .prev_i  (prev_reg),
            .shift_i (shift),
            .res_o   (lanes[g])
        );
    end

    hbkd_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (good_report),
        .lanes_i  (lanes),
        .mod_i    (modifier),
        .ready_o  (merge_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_disconnect_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        disconnect |=> (prev_reg == '0))
        else $error("disconnect did not clear the remembered keys");

    a_report_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        good_report |=> (prev_reg == $past(slots)))
        else $error("valid report was not stored as the remembered keys");

endmodule

>>> src/hbkd_lane.sv
// One decode lane: checks a single key slot against the remembered keys and translates it.
module hbkd_lane
    import hbkd_pkg::*;
(
    input  logic [CODE_W-1:0] code_i,
    input  slot_vec_t         prev_i,
    input  logic              shift_i,
    output lane_res_t         res_o
);

    logic              seen;
    logic              special;
    logic [CHAR_W-1:0] ch;

    always_comb begin
        seen = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (prev_i[i] == code_i) begin
                seen = 1'b1;
            end
        end
    end

    always_comb begin
        special = 1'b0;
        case (code_i)
            KEY_ENTER: begin
                special = 1'b1;
                ch      = CHAR_NEWLINE;
            end
            KEY_BACKSPACE: begin
                special = 1'b1;
                ch      = CHAR_BS;
            end
            KEY_TAB: begin
                special = 1'b1;
                ch      = CHAR_TAB;
            end
            KEY_ESC: begin
                special = 1'b1;
                ch      = CHAR_ESC;
            end
            KEY_SPACE: begin
                ch = CHAR_BLANK;
            end
            default: begin
                ch = translate(code_i, shift_i);
            end
        endcase
    end

    // Rollover codes 0 and 1 never produce an event.
    assign res_o.emit    = !seen && (code_i[CODE_W-1:1] != '0) && (special || (ch != '0));
    assign res_o.special = special;
    assign res_o.ascii   = ch;
    assign res_o.code    = code_i;

endmodule

>>> src/hbkd_merge.sv
// Merge stage: holds one report's lane results and sends them out in slot order.
module hbkd_merge
    import hbkd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load_i,
    input  lane_vec_t            lanes_i,
    input  logic [CODE_W-1:0]    mod_i,
    output logic                 ready_o,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    logic [SLOT_COUNT-1:0] pend_reg, pend_next;
    lane_vec_t             res_reg;
    logic [CODE_W-1:0]     mod_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]     out_code_reg;
    logic [CODE_W-1:0]     out_mod_reg;
    logic [CHAR_W-1:0]     out_ascii_reg;
    logic                  out_special_reg;
    logic                  out_last_reg;

    logic [SLOT_COUNT-1:0] pick;
    logic [SLOT_COUNT-1:0] rest;
    logic [SLOT_COUNT-1:0] pend_after;
    logic [SLOT_COUNT-1:0] emit_mask;
    lane_res_t             sel;
    logic                  drain_ok;
    logic                  move;

    // Lowest pending slot goes first.
    assign pick       = pend_reg & (~pend_reg + 1'b1);
    assign rest       = pend_reg & ~pick;
    assign drain_ok   = !out_valid_reg || m_tready;
    assign move       = drain_ok && (pend_reg != '0);
    assign pend_after = move ? rest : pend_reg;
    assign ready_o    = (pend_after == '0);

    always_comb begin
        sel = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (pick[i]) begin
                sel = sel | res_reg[i];
            end
            emit_mask[i] = lanes_i[i].emit;
        end
    end

    assign pend_next      = load_i ? emit_mask : pend_after;
    assign out_valid_next = move ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            res_reg <= lanes_i;
            mod_reg <= mod_i;
        end
        if (move) begin
            out_code_reg    <= sel.code;
            out_mod_reg     <= mod_reg;
            out_ascii_reg   <= sel.ascii;
            out_special_reg <= sel.special;
            out_last_reg    <= (rest == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_ascii_reg, out_mod_reg, out_code_reg};
    assign m_tuser  = out_special_reg;
    assign m_tlast  = out_last_reg;

    a_load_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        load_i |-> (pend_after == '0))
        else $error("report loaded while events were still pending");

    a_pick_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(pick))
        else $error("more than one slot selected");

    a_pend_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (move && !load_i) |=> ($countones(pend_reg) == $countones($past(pend_reg)) - 1))
        else $error("pending mask did not lose exactly one slot");

endmodule
